// ===== sv/lpht_pkg.sv =====
// Shared constants, payload structs and controller/datapath bundles for the
// linear-probe hash table. No dependencies.

package lpht_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BYTES   = 8;
    localparam int HANDLE_BITS = 16;

    localparam int KEY_W      = 64;
    localparam int OUT_HDL_W  = 16;
    localparam int HANDLE_W   = (HANDLE_BITS < OUT_HDL_W) ? HANDLE_BITS : OUT_HDL_W;
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SIZE_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W      = 9;
    localparam int HASH_STEPS = 8;
    localparam int DIV_STEPS  = KEY_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int HASH_SHIFT = 5;

    localparam logic [KEY_W-1:0] HASH_SEED = KEY_W'(5381);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic KIND_PUT = 1'b0;
    localparam logic KIND_GET = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [KEY_W-1:0]      key_text;
        logic [OUT_HDL_W-1:0]  entry_handle;
    } req_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [OUT_HDL_W-1:0]  found_handle;
    } rsp_item_t;

    typedef struct packed {
        logic       load;
        logic       hash_step;
        logic       div_init;
        logic       div_step;
        logic       probe_init;
        logic       probe_adv;
        logic       write_slot;
        logic       read_slot;
        logic       out_load;
        logic       cfg_we;
        logic [1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic hash_last;
        logic div_last;
        logic count_full;
        logic slot_used;
        logic key_match;
        logic probe_last;
    } dp_stat_t;

    // Keep the bytes before the first zero byte, within KEY_BYTES.
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             live;
        res  = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_W / 8; i++)
        begin
            if (i >= KEY_BYTES || raw[8*i +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/lpht_dp.sv =====
// Datapath: djb2 hash, bit-serial modulo, slot memories, used bits, count,
// size register and result register. Depends on lpht_pkg.

module lpht_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpht_pkg::dp_cmd_t             cmd,
    output lpht_pkg::dp_stat_t            stat,
    input  lpht_pkg::req_item_t           req_data,
    input  logic [lpht_pkg::CFG_W-1:0]    cfg_data,
    output lpht_pkg::rsp_item_t           rsp_data
);

    logic [lpht_pkg::CFG_W-1:0]    cfg_reg;
    logic                          kind_reg;
    logic [lpht_pkg::KEY_W-1:0]    key_reg;
    logic [lpht_pkg::HANDLE_W-1:0] handle_reg;
    logic [lpht_pkg::SIZE_W-1:0]   size_reg;
    logic [lpht_pkg::KEY_W-1:0]    hash_reg, hash_next;
    logic [lpht_pkg::SIZE_W-1:0]   rem_reg, rem_next;
    logic [lpht_pkg::STEP_W-1:0]   step_reg;
    logic [lpht_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [lpht_pkg::SIZE_W-1:0]   probe_reg;
    logic [lpht_pkg::SIZE_W-1:0]   count_reg;
    logic [lpht_pkg::TABLE_DEPTH-1:0] used_reg;
    logic [lpht_pkg::KEY_W-1:0]    rd_key_reg;
    logic [lpht_pkg::HANDLE_W-1:0] rd_handle_reg;
    lpht_pkg::rsp_item_t           rsp_reg;

    logic [lpht_pkg::KEY_W-1:0]    key_mem    [lpht_pkg::TABLE_DEPTH];
    logic [lpht_pkg::HANDLE_W-1:0] handle_mem [lpht_pkg::TABLE_DEPTH];

    logic [lpht_pkg::SIZE_W-1:0]   live_size;
    logic [7:0]                    hash_byte;
    logic [lpht_pkg::SIZE_W:0]     trial;
    logic [lpht_pkg::SIZE_W-1:0]   idx_inc;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            live_size = lpht_pkg::SIZE_W'(1);
        end
        else if (32'(cfg_reg) > lpht_pkg::TABLE_DEPTH)
        begin
            live_size = lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);
        end
        else
        begin
            live_size = lpht_pkg::SIZE_W'(cfg_reg);
        end
    end

    always_comb
    begin
        hash_byte = key_reg[{step_reg[2:0], 3'b000} +: 8];
        trial     = {rem_reg, hash_reg[lpht_pkg::KEY_W-1]};
        hash_next = hash_reg;
        rem_next  = rem_reg;
        if (cmd.hash_step && hash_byte != 8'h00)
        begin
            hash_next = (hash_reg << lpht_pkg::HASH_SHIFT) + hash_reg
                        + lpht_pkg::KEY_W'(hash_byte);
        end
        else if (cmd.div_step)
        begin
            hash_next = hash_reg << 1;
            if (trial >= {1'b0, size_reg})
            begin
                rem_next = lpht_pkg::SIZE_W'(trial - {1'b0, size_reg});
            end
            else
            begin
                rem_next = lpht_pkg::SIZE_W'(trial);
            end
        end
    end

    always_comb
    begin
        idx_inc = lpht_pkg::SIZE_W'(idx_reg) + lpht_pkg::SIZE_W'(1);
        if (idx_inc == size_reg)
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = lpht_pkg::IDX_W'(idx_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= lpht_pkg::CFG_RESET;
            count_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.write_slot)
            begin
                count_reg         <= count_reg + lpht_pkg::SIZE_W'(1);
                used_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= req_data.kind;
            key_reg    <= lpht_pkg::canon_key(req_data.key_text);
            handle_reg <= lpht_pkg::HANDLE_W'(req_data.entry_handle);
            size_reg   <= live_size;
            hash_reg   <= lpht_pkg::HASH_SEED;
            step_reg   <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            if (cmd.div_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.hash_step || cmd.div_step)
            begin
                step_reg <= step_reg + lpht_pkg::STEP_W'(1);
            end
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
        if (cmd.probe_init)
        begin
            idx_reg   <= lpht_pkg::IDX_W'(rem_reg);
            probe_reg <= '0;
        end
        else if (cmd.probe_adv)
        begin
            idx_reg   <= idx_next;
            probe_reg <= probe_reg + lpht_pkg::SIZE_W'(1);
        end
        if (cmd.out_load)
        begin
            rsp_reg.status <= cmd.res_status;
            if (cmd.res_status == lpht_pkg::ST_OK && kind_reg == lpht_pkg::KIND_GET)
            begin
                rsp_reg.found_handle <= lpht_pkg::OUT_HDL_W'(rd_handle_reg);
            end
            else
            begin
                rsp_reg.found_handle <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_slot)
        begin
            key_mem[idx_reg]    <= key_reg;
            handle_mem[idx_reg] <= handle_reg;
        end
        if (cmd.read_slot)
        begin
            rd_key_reg    <= key_mem[idx_reg];
            rd_handle_reg <= handle_mem[idx_reg];
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.hash_last  = (step_reg == lpht_pkg::STEP_W'(lpht_pkg::HASH_STEPS - 1));
    assign stat.div_last   = (step_reg == lpht_pkg::STEP_W'(lpht_pkg::DIV_STEPS - 1));
    assign stat.count_full = (count_reg >= size_reg);
    assign stat.slot_used  = used_reg[idx_reg];
    assign stat.key_match  = used_reg[idx_reg] && (rd_key_reg == key_reg);
    assign stat.probe_last = (probe_reg == size_reg - lpht_pkg::SIZE_W'(1));
    assign rsp_data        = rsp_reg;

endmodule

// ===== sv/lpht_ctrl.sv =====
// Controller: sequences hash, modulo and probing for one operation and owns
// the handshakes. Depends on lpht_pkg.

module lpht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    output lpht_pkg::dp_cmd_t  cmd,
    input  lpht_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_DIV,
        S_SETUP,
        S_INS,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] res_reg, res_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        cmd            = '0;
        cmd.res_status = res_reg;
        cmd.cfg_we     = cfg_valid && cfg_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.probe_init = 1'b1;
                if (stat.kind == lpht_pkg::KIND_GET)
                begin
                    state_next = S_LOOK_RD;
                end
                else if (stat.count_full)
                begin
                    res_next   = lpht_pkg::ST_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                if (!stat.slot_used)
                begin
                    cmd.write_slot = 1'b1;
                    res_next       = lpht_pkg::ST_OK;
                    state_next     = S_FINISH;
                end
                else if (stat.probe_last)
                begin
                    res_next   = lpht_pkg::ST_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                end
            end
            S_LOOK_RD:
            begin
                cmd.read_slot = 1'b1;
                state_next    = S_LOOK_CHK;
            end
            S_LOOK_CHK:
            begin
                if (stat.key_match)
                begin
                    res_next   = lpht_pkg::ST_OK;
                    state_next = S_FINISH;
                end
                else if (stat.probe_last)
                begin
                    res_next   = lpht_pkg::ST_MISSING;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_LOOK_RD;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            res_reg       <= lpht_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
// Usage:
//   req channel (req_valid/req_stall/req_data): one put (kind 0) or get
//   (kind 1) per transfer. rsp channel (rsp_valid/rsp_stall/rsp_data): one
//   status/handle result per request, in order. cfg channel (cfg_valid/
//   cfg_ready/cfg_data): writes table_size; ready only while idle.
// Sequence from request transfer to rsp_valid: a hash phase over the key
//   bytes, a modulo phase (one remainder bit per cycle), a setup step, then
//   the probe, where a put checks each slot's used mark and a get reads each
//   slot (registered slot memory read, then compare); then the result is
//   loaded once the output register is free. A put refused by count skips
//   the probe.
// One request at a time: req_stall is high from the transfer until the
//   result is loaded. A finished result waits in the output register while
//   the next request is taken; if that one finishes while rsp_stall still
//   holds the earlier result, it waits for the register to drain.
// Reset clears all used marks, the entry count and any pending result, and
//   sets table_size to 256. Slot contents are not cleared.

module linear_probe_hash_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lpht_pkg::req_item_t           req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lpht_pkg::rsp_item_t           rsp_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpht_pkg::CFG_W-1:0]    cfg_data
);

    lpht_pkg::dp_cmd_t  cmd;
    lpht_pkg::dp_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lpht_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_data (req_data),
        .cfg_data (cfg_data),
        .rsp_data (rsp_data)
    );

endmodule

// ===== sv/lpht_checker.sv =====
// Port-level assertions for linear_probe_hash_table, attached by bind.
// Depends on lpht_pkg.

module lpht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input lpht_pkg::rsp_item_t           rsp_data,
    input logic                          cfg_ready
);

    // Held result stays put while stalled.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // Stays busy at the start of the hash phase after a request transfer.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall ##1 req_stall ##1 req_stall)
        else $error("request taken during busy window");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status == lpht_pkg::ST_OK
                   || rsp_data.status == lpht_pkg::ST_FULL
                   || rsp_data.status == lpht_pkg::ST_MISSING)
        else $error("bad status code");

    a_fail_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != lpht_pkg::ST_OK |-> rsp_data.found_handle == '0)
        else $error("nonzero handle on failed operation");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !req_stall)
        else $error("config ready while busy");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
